/* hdl/complex_number_alu_top_assert.svh */
// Assertion macros for the complex arithmetic unit.
`ifndef COMPLEX_NUMBER_ALU_TOP_ASSERT_SVH
`define COMPLEX_NUMBER_ALU_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CNA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("complex_number_alu_top: check failed");
`define CNA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("complex_number_alu_top: check failed");
`else
`define CNA_ASSERT(lbl, prop)
`define CNA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

/* hdl/cna_pkg.sv */
// Operation codes and status codes of the complex arithmetic unit.
package cna_pkg;
  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_EQ  = 3'd4,
    OP_NE  = 3'd5
  } op_t;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_DIV0 = 2'd1;
  localparam status_t ST_SAT  = 2'd2;
endpackage

/* hdl/complex_number_alu_top.sv */
// Complex arithmetic unit: add, subtract, multiply, divide and compare on fixed-point pairs.
// The unit is a single pipeline that accepts one operation per cycle while in_stall is low
// and returns one result per operation in order. Every operation passes through the same
// stages, with Q8.8 parts by default: four stages for operand capture, products, sums and
// magnitudes, one restoring-division stage per quotient bit, and the output register.
// The whole pipeline halts while a result waits under stall.
// Division truncates toward zero; out-of-range parts saturate with status 2, and a zero
// divisor returns zero parts with status 1.
module complex_number_alu_top #(
  parameter int PART_WIDTH    = 16,
  parameter int FRACTION_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   operation,
  input  logic signed [PART_WIDTH-1:0] a_real,
  input  logic signed [PART_WIDTH-1:0] a_imag,
  input  logic signed [PART_WIDTH-1:0] b_real,
  input  logic signed [PART_WIDTH-1:0] b_imag,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [PART_WIDTH-1:0] result_real,
  output logic signed [PART_WIDTH-1:0] result_imag,
  output logic                         compare_true,
  output cna_pkg::status_t             status
);
  import cna_pkg::*;

  localparam int W  = PART_WIDTH;
  localparam int F  = FRACTION_BITS;
  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int D  = 2 * W + F;

  localparam logic [W-1:0] P_MAX   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] P_MIN   = {1'b1, {(W-1){1'b0}}};
  localparam logic [W:0]   LIM_POS = {2'b00, {(W-1){1'b1}}};
  localparam logic [W:0]   LIM_NEG = {2'b01, {(W-1){1'b0}}};

  // Saturates a sign and magnitude pair; the result is {saturated, part}.
  function automatic logic [W:0] sat_mag(input logic neg, input logic ovf,
                                         input logic [W:0] m);
    logic [W-1:0] v;
    logic         s;
    begin
      s = ovf || (neg ? (m > LIM_NEG) : (m > LIM_POS));
      if (s) begin
        v = neg ? P_MIN : P_MAX;
      end else begin
        v = neg ? (~m[W-1:0] + 1'b1) : m[W-1:0];
      end
      return {s, v};
    end
  endfunction

  function automatic logic [W:0] sat_sum(input logic [W:0] x);
    begin
      if (x[W] != x[W-1]) begin
        return {1'b1, x[W] ? P_MIN : P_MAX};
      end
      return {1'b0, x[W-1:0]};
    end
  endfunction

  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // Stage 1: operand capture.
  logic               v1;
  op_t                op1;
  logic signed [W-1:0] ar1, ai1, br1, bi1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      op1 <= op_t'(operation);
      ar1 <= a_real;
      ai1 <= a_imag;
      br1 <= b_real;
      bi1 <= b_imag;
    end
  end

  // Stage 2: products, add and subtract, equality.
  logic                v2;
  op_t                 op2;
  logic signed [PW-1:0] prr, pii, pir, pri, pbr, pbi;
  logic [W:0]           add_re, add_im, sub_re, sub_im;
  logic [W-1:0]         as_re2, as_im2;
  logic                 as_sat2, eq2;
  logic [W-1:0]         as_re_next, as_im_next;
  logic                 as_sat_next;

  always_comb begin
    add_re = sat_sum({ar1[W-1], ar1} + {br1[W-1], br1});
    add_im = sat_sum({ai1[W-1], ai1} + {bi1[W-1], bi1});
    sub_re = sat_sum({ar1[W-1], ar1} - {br1[W-1], br1});
    sub_im = sat_sum({ai1[W-1], ai1} - {bi1[W-1], bi1});
    if (op1 == OP_SUB) begin
      as_re_next  = sub_re[W-1:0];
      as_im_next  = sub_im[W-1:0];
      as_sat_next = sub_re[W] | sub_im[W];
    end else begin
      as_re_next  = add_re[W-1:0];
      as_im_next  = add_im[W-1:0];
      as_sat_next = add_re[W] | add_im[W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      op2     <= op1;
      prr     <= ar1 * br1;
      pii     <= ai1 * bi1;
      pir     <= ai1 * br1;
      pri     <= ar1 * bi1;
      pbr     <= br1 * br1;
      pbi     <= bi1 * bi1;
      as_re2  <= as_re_next;
      as_im2  <= as_im_next;
      as_sat2 <= as_sat_next;
      eq2     <= (ar1 == br1) && (ai1 == bi1);
    end
  end

  // Stage 3: sums of products and the divisor.
  logic                 v3;
  op_t                  op3;
  logic signed [SW-1:0] mr3, mi3, dr3, di3;
  logic [PW-1:0]        den3;
  logic [W-1:0]         as_re3, as_im3;
  logic                 as_sat3, eq3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      op3     <= op2;
      mr3     <= SW'(prr) - SW'(pii);
      mi3     <= SW'(pir) + SW'(pri);
      dr3     <= SW'(prr) + SW'(pii);
      di3     <= SW'(pir) - SW'(pri);
      den3    <= $unsigned(pbr) + $unsigned(pbi);
      as_re3  <= as_re2;
      as_im3  <= as_im2;
      as_sat3 <= as_sat2;
      eq3     <= eq2;
    end
  end

  // Division pipeline arrays; index 0 is written by stage 4.
  logic          dv     [0:D];
  op_t           dop    [0:D];
  logic [W-1:0]  dres_re[0:D];
  logic [W-1:0]  dres_im[0:D];
  logic          dsat   [0:D];
  logic          dcmp   [0:D];
  logic [PW-1:0] dden   [0:D];
  logic          dneg_re[0:D];
  logic          dneg_im[0:D];
  logic [D-1:0]  dn_re  [0:D];
  logic [D-1:0]  dn_im  [0:D];
  logic [PW-1:0] drem_re[0:D];
  logic [PW-1:0] drem_im[0:D];
  logic [W:0]    dq_re  [0:D];
  logic [W:0]    dq_im  [0:D];
  logic          dovf_re[0:D];
  logic          dovf_im[0:D];

  // Stage 4: magnitudes, multiply result and per-operation selection.
  logic [SW-1:0] mr_abs, mi_abs, dr_abs, di_abs;
  logic [PW-1:0] mr_sh, mi_sh;
  logic [W:0]    mul_re, mul_im;
  logic [W-1:0]  res_re_next, res_im_next;
  logic          sat_next, cmp_next;

  always_comb begin
    mr_abs = mr3[SW-1] ? -mr3 : mr3;
    mi_abs = mi3[SW-1] ? -mi3 : mi3;
    dr_abs = dr3[SW-1] ? -dr3 : dr3;
    di_abs = di3[SW-1] ? -di3 : di3;
    mr_sh  = mr_abs[PW-1:0] >> F;
    mi_sh  = mi_abs[PW-1:0] >> F;
    mul_re = sat_mag(mr3[SW-1], |mr_sh[PW-1:W+1], mr_sh[W:0]);
    mul_im = sat_mag(mi3[SW-1], |mi_sh[PW-1:W+1], mi_sh[W:0]);
    res_re_next = '0;
    res_im_next = '0;
    sat_next    = 1'b0;
    cmp_next    = 1'b0;
    case (op3)
      OP_ADD, OP_SUB: begin
        res_re_next = as_re3;
        res_im_next = as_im3;
        sat_next    = as_sat3;
      end
      OP_MUL: begin
        res_re_next = mul_re[W-1:0];
        res_im_next = mul_im[W-1:0];
        sat_next    = mul_re[W] | mul_im[W];
      end
      OP_EQ: cmp_next = eq3;
      OP_NE: cmp_next = !eq3;
      default: begin
        res_re_next = '0;
        res_im_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (en) begin
      dv[0] <= v3;
    end
    if (en) begin
      dop[0]     <= op3;
      dres_re[0] <= res_re_next;
      dres_im[0] <= res_im_next;
      dsat[0]    <= sat_next;
      dcmp[0]    <= cmp_next;
      dden[0]    <= den3;
      dneg_re[0] <= dr3[SW-1];
      dneg_im[0] <= di3[SW-1];
      dn_re[0]   <= {dr_abs[PW-1:0], {F{1'b0}}};
      dn_im[0]   <= {di_abs[PW-1:0], {F{1'b0}}};
      drem_re[0] <= '0;
      drem_im[0] <= '0;
      dq_re[0]   <= '0;
      dq_im[0]   <= '0;
      dovf_re[0] <= 1'b0;
      dovf_im[0] <= 1'b0;
    end
  end

  // One restoring-division step per stage for both parts.
  for (genvar k = 0; k < D; k++) begin : g_div
    logic [PW:0] rs_re, rs_im;
    logic        ge_re, ge_im;

    always_comb begin
      rs_re = {drem_re[k], dn_re[k][D-1]};
      rs_im = {drem_im[k], dn_im[k][D-1]};
      ge_re = rs_re >= {1'b0, dden[k]};
      ge_im = rs_im >= {1'b0, dden[k]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (en) begin
        dv[k+1] <= dv[k];
      end
      if (en) begin
        dop[k+1]     <= dop[k];
        dres_re[k+1] <= dres_re[k];
        dres_im[k+1] <= dres_im[k];
        dsat[k+1]    <= dsat[k];
        dcmp[k+1]    <= dcmp[k];
        dden[k+1]    <= dden[k];
        dneg_re[k+1] <= dneg_re[k];
        dneg_im[k+1] <= dneg_im[k];
        dn_re[k+1]   <= dn_re[k] << 1;
        dn_im[k+1]   <= dn_im[k] << 1;
        drem_re[k+1] <= ge_re ? PW'(rs_re - {1'b0, dden[k]}) : rs_re[PW-1:0];
        drem_im[k+1] <= ge_im ? PW'(rs_im - {1'b0, dden[k]}) : rs_im[PW-1:0];
        dq_re[k+1]   <= {dq_re[k][W-1:0], ge_re};
        dq_im[k+1]   <= {dq_im[k][W-1:0], ge_im};
        dovf_re[k+1] <= dovf_re[k] | dq_re[k][W];
        dovf_im[k+1] <= dovf_im[k] | dq_im[k][W];
      end
    end
  end

  // Output stage: division saturation and status.
  logic [W:0]   qs_re, qs_im;
  logic [W-1:0] out_re_next, out_im_next;
  logic         out_cmp_next;
  status_t      out_st_next;

  always_comb begin
    qs_re = sat_mag(dneg_re[D], dovf_re[D], dq_re[D]);
    qs_im = sat_mag(dneg_im[D], dovf_im[D], dq_im[D]);
    out_re_next  = dres_re[D];
    out_im_next  = dres_im[D];
    out_cmp_next = dcmp[D];
    out_st_next  = dsat[D] ? ST_SAT : ST_OK;
    if (dop[D] == OP_DIV) begin
      if (dden[D] == '0) begin
        out_re_next = '0;
        out_im_next = '0;
        out_st_next = ST_DIV0;
      end else begin
        out_re_next = qs_re[W-1:0];
        out_im_next = qs_im[W-1:0];
        out_st_next = (qs_re[W] | qs_im[W]) ? ST_SAT : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv[D];
    end
    if (en) begin
      result_real  <= out_re_next;
      result_imag  <= out_im_next;
      compare_true <= out_cmp_next;
      status       <= out_st_next;
    end
  end

`include "complex_number_alu_top_assert.svh"

  `CNA_ASSERT(a_div0_zero,
    out_valid && status == ST_DIV0 |-> result_real == '0 && result_imag == '0)
  `CNA_ASSERT(a_cmp_ok, out_valid && compare_true |-> status == ST_OK && result_real == '0)
  `CNA_ASSERT(a_sat_edge, out_valid && status == ST_SAT |->
    result_real == P_MAX || result_real == P_MIN || result_imag == P_MAX || result_imag == P_MIN)
  `CNA_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(result_real))

endmodule

/* dv/complex_number_alu_top_test.sv */
// Self-checking testbench for the complex arithmetic unit with an in-order result scoreboard.
`timescale 1ns / 100ps

module complex_number_alu_top_test;
  import cna_pkg::*;

  localparam int PW = 16;
  localparam int FB = 8;
  localparam longint PMAX = 32767;
  localparam longint PMIN = -32768;
  localparam int N_RANDOM = 1300;

  typedef struct packed {
    logic [PW-1:0] re;
    logic [PW-1:0] im;
    logic          cmp;
    status_t       st;
  } alu_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] operation = 3'd0;
  logic signed [PW-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [PW-1:0] result_real, result_imag;
  logic compare_true;
  status_t status;

  int errors = 0;
  int sent = 0;
  int received = 0;
  int n_div0 = 0;
  int n_sat = 0;
  bit stim_done = 0;

  always #2 clk = ~clk;

  complex_number_alu_top #(.PART_WIDTH(PW), .FRACTION_BITS(FB)) u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .operation(operation), .a_real(a_real), .a_imag(a_imag),
    .b_real(b_real), .b_imag(b_imag), .out_valid(out_valid),
    .out_stall(out_stall), .result_real(result_real),
    .result_imag(result_imag), .compare_true(compare_true), .status(status)
  );

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at result %0d: %s got %0d expected %0d", received, what, got, want);
    errors++;
  endtask

  function automatic longint clamp(input longint v, inout bit sat);
    if (v > PMAX) begin
      sat = 1;
      return PMAX;
    end
    if (v < PMIN) begin
      sat = 1;
      return PMIN;
    end
    return v;
  endfunction

  // Products fit comfortably in 64 bits for 16-bit parts, so exact integer math is used.
  function automatic longint trunc_shift(input longint v);
    longint m;
    m = (v < 0) ? -v : v;
    m = m >>> FB;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint quot_part(input longint num, input longint den, inout bit sat);
    longint m, q;
    m = (num < 0) ? -num : num;
    q = (m * (longint'(1) << FB)) / den;
    return clamp((num < 0) ? -q : q, sat);
  endfunction

  function automatic alu_result_t complex_calc(input logic [2:0] op,
      input logic signed [PW-1:0] ar, ai, br, bi);
    alu_result_t r;
    longint xr, xi, yr, yi, rr, ri, den;
    bit sat;
    xr = ar; xi = ai; yr = br; yi = bi;
    rr = 0; ri = 0; sat = 0;
    r = '0;
    case (op)
      OP_ADD: begin
        rr = clamp(xr + yr, sat);
        ri = clamp(xi + yi, sat);
      end
      OP_SUB: begin
        rr = clamp(xr - yr, sat);
        ri = clamp(xi - yi, sat);
      end
      OP_MUL: begin
        rr = clamp(trunc_shift(xr * yr - xi * yi), sat);
        ri = clamp(trunc_shift(xi * yr + xr * yi), sat);
      end
      OP_DIV: begin
        den = yr * yr + yi * yi;
        if (den == 0) r.st = ST_DIV0;
        else begin
          rr = quot_part(xr * yr + xi * yi, den, sat);
          ri = quot_part(xi * yr - xr * yi, den, sat);
        end
      end
      OP_EQ: r.cmp = (ar == br && ai == bi);
      OP_NE: r.cmp = !(ar == br && ai == bi);
      default: ;
    endcase
    if (sat) r.st = ST_SAT;
    r.re = rr[PW-1:0];
    r.im = ri[PW-1:0];
    return r;
  endfunction

  class result_board;
    alu_result_t pending[$];

    function void note_operands(input logic [2:0] op, input logic signed [PW-1:0] ar, ai, br, bi);
      pending.push_back(complex_calc(op, ar, ai, br, bi));
    endfunction

    task check_result(input alu_result_t got);
      alu_result_t want;
      if (pending.size() == 0) begin
        report_mismatch("results outstanding", 0, 1);
        return;
      end
      want = pending.pop_front();
      if (got.re !== want.re) report_mismatch("result_real",
          longint'($signed(got.re)), longint'($signed(want.re)));
      if (got.im !== want.im) report_mismatch("result_imag",
          longint'($signed(got.im)), longint'($signed(want.im)));
      if (got.cmp !== want.cmp) report_mismatch("compare_true", got.cmp, want.cmp);
      if (got.st !== want.st) report_mismatch("status", got.st, want.st);
      if (want.st == ST_DIV0) n_div0++;
      if (want.st == ST_SAT) n_sat++;
    endtask
  endclass

  result_board board = new();

  // One transfer per call; valid stays high across back-to-back items.
  task automatic send_item(input logic [2:0] op, input logic signed [PW-1:0] ar, ai, br, bi);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    a_real <= ar; a_imag <= ai; b_real <= br; b_imag <= bi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_operands(op, ar, ai, br, bi);
    sent++;
  endtask

  function automatic logic [PW-1:0] pick_part();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      3: return 16'(int'($urandom_range(0, 1024)) - 512);
      4: return 16'($urandom_range(0, 15)) << $urandom_range(0, 12);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic signed [PW-1:0] ar, ai, br, bi;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed: every operation, both extremes, zero divisor, equal operands, unused codes.
    send_item(OP_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
    send_item(OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    send_item(OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
    send_item(OP_SUB, 16'h0100, 16'h0200, 16'h0100, 16'h0200);
    send_item(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_item(OP_MUL, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000);
    send_item(OP_MUL, 16'h0100, 16'h0000, 16'hff80, 16'h0001);
    send_item(OP_MUL, 16'hffff, 16'h0000, 16'h0001, 16'h0000);
    send_item(OP_DIV, 16'h0100, 16'h0100, 16'h0000, 16'h0000);
    send_item(OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'h0001);
    send_item(OP_DIV, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
    send_item(OP_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h8000);
    send_item(OP_DIV, 16'hff00, 16'h0300, 16'h0200, 16'h0000);
    send_item(OP_DIV, 16'h0001, 16'h0000, 16'h0300, 16'h0000);
    send_item(OP_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8000);
    send_item(OP_EQ, 16'h1234, 16'h8000, 16'h1234, 16'h8001);
    send_item(OP_NE, 16'h7fff, 16'h0000, 16'h7fff, 16'h0000);
    send_item(OP_NE, 16'h7fff, 16'h0000, 16'h7ffe, 16'h0000);
    send_item(3'd6, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
    send_item(3'd7, 16'h7fff, 16'h8000, 16'h0001, 16'h0000);
    for (int i = 0; i < N_RANDOM; i++) begin
      ar = pick_part(); ai = pick_part();
      br = pick_part(); bi = pick_part();
      if ($urandom_range(0, 9) == 0) begin
        br = ar;
        bi = ai;
      end
      if ($urandom_range(0, 15) == 0) begin
        br = '0;
        bi = '0;
      end
      send_item(3'($urandom_range(0, 7)), ar, ai, br, bi);
    end
    in_valid <= 1'b0;
    stim_done = 1;
  end

  // Receiver: fresh stall draw per result, with occasional stall-free stretches.
  int stall_left = 0;
  int calm_left = 0;
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      board.check_result('{re: result_real, im: result_imag, cmp: compare_true, st: status});
      received++;
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (calm_left > 0) begin
      calm_left <= calm_left - 1;
      out_stall <= 1'b0;
    end else if (out_valid && !out_stall || $urandom_range(0, 7) == 0) begin
      if ($urandom_range(0, 19) == 0) begin
        calm_left <= 60;
        out_stall <= 1'b0;
      end else begin
        stall_left <= $urandom_range(0, 11);
        out_stall <= 1'b0;
      end
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    wait (stim_done);
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d operations, checked %0d results in order", sent, received);
    $display("zero divisors seen: %0d, saturated results seen: %0d", n_div0, n_sat);
    if (errors == 0 && board.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", board.pending.size());
    $display("status: fail");
    $finish;
  end
endmodule
